// ===== src/mkm_pkg.sv =====
package mkm_pkg;

  localparam int CM_AW    = 7;
  localparam int CM_DEPTH = 128;

  localparam logic [0:0] CFG_IGNORE_CASE = 1'b0;
  localparam logic [0:0] CFG_EXACT_MODE  = 1'b1;

  typedef enum logic [2:0] {
    REQ_PAT_BYTE  = 3'd0,
    REQ_END_PAT   = 3'd1,
    REQ_BUILD     = 3'd2,
    REQ_TEXT_BYTE = 3'd3,
    REQ_END_TEXT  = 3'd4,
    REQ_CLEAR_ALL = 3'd5
  } req_e_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_MATCH    = 3'd1,
    STAT_NOMATCH  = 3'd2,
    STAT_ST_FULL  = 3'd3,
    STAT_CLS_FULL = 3'd4,
    STAT_BAD_BYTE = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_CM_LO,
    ST_CM_HI,
    ST_CM_K,
    ST_CM_WHI,
    ST_TX_CM,
    ST_TX_K,
    ST_TX_ACC,
    ST_ED_TR,
    ST_ED_ND,
    ST_ED_CHK,
    ST_GO_FAIL,
    ST_EP_RD,
    ST_EP_WR,
    ST_ET_RD,
    ST_ET_ACC,
    ST_BD_SD,
    ST_BD_SDF,
    ST_BD_C,
    ST_BD_ACCF,
    ST_BD_WR,
    ST_BD_POP,
    ST_BD_QRD,
    ST_RESP
  } eng_state_t;

  typedef enum logic [2:0] {
    LK_PAT,
    LK_EXACT,
    LK_GO_TEXT,
    LK_EDGE,
    LK_GO_BUILD
  } lk_mode_t;

  typedef struct packed {
    logic ignore_case;
    logic exact_mode;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [CM_AW-1:0] waddr;
    logic [CM_AW-1:0] raddr;
    logic             clear;
  } cm_ctl_t;

endpackage

// ===== src/mkm_if.sv =====
interface req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface res_if #(parameter int UW = 9);
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [UW-1:0] states_used;

  modport source (output valid, output status, output states_used, input ready);
  modport sink (input valid, input status, input states_used, output ready);
endinterface

// ===== src/multi_keyword_matcher.sv =====
// channel  dir  handshake    word
// req      in   valid/ready  req_type[2:0], data_byte[7:0]
// res      out  valid/ready  status[2:0], states_used
// cfg      in   cfg_we       cfg_index[0], cfg_data[0]
//
// Every lookup of an edge reads the transition, then checks the node; each
// failure link followed adds another lookup. A text byte maps its class and
// runs a lookup, following failure links unless in exact mode; a pattern byte
// maps and writes both cases of its class, then runs one lookup, and ends early
// when poisoned, bad or on a full class table. Build visits each state and
// class, with the failure walk of each child. Reset and clear all sweep nothing.
// A result waits in the output register while the next word is taken.
module multi_keyword_matcher #(
  parameter int MAX_STATES  = 256,
  parameter int MAX_CLASSES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [0:0] cfg_data,
  req_if.sink        req,
  res_if.source      res
);
  import mkm_pkg::*;

  localparam int CNTW = $clog2(MAX_STATES + 1);

  cfg_t            cfg;
  logic            eng_valid, eng_ready;
  status_t         eng_status;
  logic [CNTW-1:0] eng_used;
  logic            out_valid;
  status_t         out_status;
  logic [CNTW-1:0] out_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IGNORE_CASE: cfg.ignore_case <= cfg_data[0];
        CFG_EXACT_MODE:  cfg.exact_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mkm_engine #(.MAX_STATES(MAX_STATES), .MAX_CLASSES(MAX_CLASSES)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_type   (req.req_type),
    .in_byte   (req.data_byte),
    .res_valid (eng_valid),
    .res_ready (eng_ready),
    .res_status(eng_status),
    .res_used  (eng_used)
  );

  assign eng_ready = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_ready) begin
      out_valid <= eng_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_ready && eng_valid) begin
      out_status <= eng_status;
      out_used   <= eng_used;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.states_used = out_used;

endmodule

// ===== src/mkm_ram.sv =====
module mkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mkm_class_map.sv =====
module mkm_class_map #(
  parameter int CW = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  mkm_pkg::cm_ctl_t ctl,
  input  logic [CW-1:0]    wdata,
  output logic [CW-1:0]    rdata
);
  import mkm_pkg::*;

  logic [CM_DEPTH-1:0] vld;
  logic                vld_rd;
  logic [CW-1:0]       ram_q;

  mkm_ram #(.WIDTH(CW), .DEPTH(CM_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ctl.we),
    .waddr(ctl.waddr),
    .wdata(wdata),
    .raddr(ctl.raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      vld    <= '0;
      vld_rd <= 1'b0;
    end else begin
      if (ctl.we) begin
        vld[ctl.waddr] <= 1'b1;
      end
      vld_rd <= vld[ctl.raddr];
    end
  end

  // entries never written read as class 0
  assign rdata = vld_rd ? ram_q : '0;

endmodule

// ===== src/mkm_engine.sv =====
module mkm_engine #(
  parameter int MAX_STATES  = 256,
  parameter int MAX_CLASSES = 64,
  localparam int CNTW = $clog2(MAX_STATES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  mkm_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_type,
  input  logic [7:0]        in_byte,
  output logic              res_valid,
  input  logic              res_ready,
  output mkm_pkg::status_t  res_status,
  output logic [CNTW-1:0]   res_used
);
  import mkm_pkg::*;

  localparam int SW     = $clog2(MAX_STATES);
  localparam int CW     = $clog2(MAX_CLASSES);
  localparam int CCW    = $clog2(MAX_CLASSES + 1);
  localparam int TDEPTH = MAX_STATES * MAX_CLASSES;
  localparam int TAW    = $clog2(TDEPTH);

  typedef struct packed {
    logic          acc;
    logic [SW-1:0] fail;
    logic [SW-1:0] parent;
    logic [CW-1:0] cls;
  } node_t;

  eng_state_t state, state_next;
  lk_mode_t   lk, lk_next;
  status_t    status, status_next;

  logic [SW-1:0]  cursor, cursor_next, scan, scan_next, s, s_next, t, t_next;
  logic [SW-1:0]  sd, sd_next, sd_fail, sd_fail_next, snew, snew_next, f, f_next;
  logic [SW-1:0]  head, head_next, tail, tail_next;
  logic [CNTW-1:0] scount, scount_next;
  logic [CCW-1:0]  ccount, ccount_next, cidx, cidx_next;
  logic [CW-1:0]   k, k_next, klo, klo_next, kk;
  logic [CM_AW-1:0] lo, lo_next, hi, hi_next;
  logic match, match_next, dead, dead_next, poison, poison_next, accf, accf_next;

  logic           tr_we;
  logic [TAW-1:0] tr_addr;
  logic [SW-1:0]  tr_rdata;
  logic           nd_we;
  logic [SW-1:0]  nd_waddr, nd_raddr;
  node_t          nd_wdata, nd_q;
  logic           q_we;
  logic [SW-1:0]  q_rdata;
  cm_ctl_t        cm_ctl;
  logic [CW-1:0]  cm_wdata, cm_rdata;
  logic           hit;
  logic [CM_AW-1:0] b7;

  assign tr_addr = TAW'(s) * TAW'(MAX_CLASSES) + TAW'(k);
  assign hit = (t != '0) && (CNTW'(t) < scount) && (nd_q.parent == s) && (nd_q.cls == k);
  assign b7 = in_byte[CM_AW-1:0];

  mkm_ram #(.WIDTH(SW), .DEPTH(TDEPTH)) u_trans (
    .clk(clk), .we(tr_we), .waddr(tr_addr), .wdata(scount[SW-1:0]),
    .raddr(tr_addr), .rdata(tr_rdata)
  );

  mkm_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_STATES)) u_node (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .raddr(nd_raddr), .rdata(nd_q)
  );

  mkm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail), .wdata(t),
    .raddr(head), .rdata(q_rdata)
  );

  mkm_class_map #(.CW(CW)) u_cmap (
    .clk(clk), .rst(rst), .ctl(cm_ctl), .wdata(cm_wdata), .rdata(cm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_INIT;
      scount <= CNTW'(1);
      ccount <= CCW'(1);
      cursor <= '0;
      scan   <= '0;
      match  <= 1'b0;
      dead   <= 1'b0;
      poison <= 1'b0;
    end else begin
      state  <= state_next;
      scount <= scount_next;
      ccount <= ccount_next;
      cursor <= cursor_next;
      scan   <= scan_next;
      match  <= match_next;
      dead   <= dead_next;
      poison <= poison_next;
    end
  end

  always_ff @(posedge clk) begin
    lk      <= lk_next;
    status  <= status_next;
    s       <= s_next;
    t       <= t_next;
    sd      <= sd_next;
    sd_fail <= sd_fail_next;
    snew    <= snew_next;
    f       <= f_next;
    head    <= head_next;
    tail    <= tail_next;
    cidx    <= cidx_next;
    k       <= k_next;
    klo     <= klo_next;
    lo      <= lo_next;
    hi      <= hi_next;
    accf    <= accf_next;
  end

  always_comb begin
    state_next   = state;
    lk_next      = lk;
    status_next  = status;
    cursor_next  = cursor;
    scan_next    = scan;
    s_next       = s;
    t_next       = t;
    sd_next      = sd;
    sd_fail_next = sd_fail;
    snew_next    = snew;
    f_next       = f;
    head_next    = head;
    tail_next    = tail;
    scount_next  = scount;
    ccount_next  = ccount;
    cidx_next    = cidx;
    k_next       = k;
    klo_next     = klo;
    lo_next      = lo;
    hi_next      = hi;
    match_next   = match;
    dead_next    = dead;
    poison_next  = poison;
    accf_next    = accf;
    kk           = '0;

    in_ready     = 1'b0;
    res_valid    = 1'b0;
    tr_we        = 1'b0;
    nd_we        = 1'b0;
    nd_waddr     = '0;
    nd_wdata     = '0;
    nd_raddr     = '0;
    q_we         = 1'b0;
    cm_ctl       = '{we: 1'b0, waddr: lo, raddr: lo, clear: 1'b0};
    cm_wdata     = k;

    unique case (state)
      ST_INIT: begin
        nd_we      = 1'b1;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_type)
            REQ_PAT_BYTE: begin
              lo_next = b7;
              hi_next = b7;
              if (cfg.ignore_case && b7 >= 7'h41 && b7 <= 7'h5A) lo_next = b7 + 7'd32;
              if (cfg.ignore_case && b7 >= 7'h61 && b7 <= 7'h7A) hi_next = b7 - 7'd32;
              status_next = STAT_OK;
              if (poison) begin
                state_next = ST_RESP;
              end else if (in_byte[7]) begin
                poison_next = 1'b1;
                status_next = STAT_BAD_BYTE;
                state_next  = ST_RESP;
              end else begin
                state_next = ST_CM_LO;
              end
            end
            REQ_END_PAT: begin
              status_next = STAT_OK;
              if (poison) begin
                cursor_next = '0;
                poison_next = 1'b0;
                state_next  = ST_RESP;
              end else begin
                state_next = ST_EP_RD;
              end
            end
            REQ_BUILD: begin
              sd_next    = '0;
              head_next  = '0;
              tail_next  = '0;
              state_next = ST_BD_SD;
            end
            REQ_TEXT_BYTE: begin
              lo_next = b7;
              if (!in_byte[7] && !(cfg.exact_mode ? dead : match)) begin
                state_next = ST_TX_CM;
              end
            end
            REQ_END_TEXT: begin
              state_next = ST_ET_RD;
            end
            REQ_CLEAR_ALL: begin
              nd_we        = 1'b1;
              cm_ctl.clear = 1'b1;
              scount_next  = CNTW'(1);
              ccount_next  = CCW'(1);
              cursor_next  = '0;
              scan_next    = '0;
              match_next   = 1'b0;
              dead_next    = 1'b0;
              poison_next  = 1'b0;
              status_next  = STAT_OK;
              state_next   = ST_RESP;
            end
            default: ;
          endcase
        end
      end
      ST_CM_LO: begin
        state_next = ST_CM_HI;
      end
      ST_CM_HI: begin
        cm_ctl.raddr = hi;
        klo_next     = cm_rdata;
        state_next   = ST_CM_K;
      end
      ST_CM_K: begin
        kk = (klo != '0) ? klo : cm_rdata;
        if (kk == '0 && ccount >= CCW'(MAX_CLASSES)) begin
          poison_next = 1'b1;
          status_next = STAT_CLS_FULL;
          state_next  = ST_RESP;
        end else begin
          if (kk == '0) begin
            kk          = ccount[CW-1:0];
            ccount_next = ccount + CCW'(1);
          end
          cm_ctl.we  = 1'b1;
          cm_wdata   = kk;
          k_next     = kk;
          state_next = ST_CM_WHI;
        end
      end
      ST_CM_WHI: begin
        cm_ctl.we    = 1'b1;
        cm_ctl.waddr = hi;
        s_next       = cursor;
        lk_next      = LK_PAT;
        state_next   = ST_ED_TR;
      end
      ST_TX_CM: begin
        state_next = ST_TX_K;
      end
      ST_TX_K: begin
        k_next     = cm_rdata;
        s_next     = scan;
        lk_next    = cfg.exact_mode ? LK_EXACT : LK_GO_TEXT;
        state_next = ST_ED_TR;
      end
      ST_TX_ACC: begin
        if (nd_q.acc) match_next = 1'b1;
        state_next = ST_IDLE;
      end
      ST_ED_TR: begin
        state_next = ST_ED_ND;
      end
      ST_ED_ND: begin
        t_next     = tr_rdata;
        nd_raddr   = tr_rdata;
        state_next = ST_ED_CHK;
      end
      ST_ED_CHK: begin
        unique case (lk)
          LK_PAT: begin
            status_next = STAT_OK;
            state_next  = ST_RESP;
            if (hit) begin
              cursor_next = t;
            end else if (scount >= CNTW'(MAX_STATES)) begin
              poison_next = 1'b1;
              status_next = STAT_ST_FULL;
            end else begin
              tr_we       = 1'b1;
              nd_we       = 1'b1;
              nd_waddr    = scount[SW-1:0];
              nd_wdata    = '{acc: 1'b0, fail: '0, parent: s, cls: k};
              cursor_next = scount[SW-1:0];
              scount_next = scount + CNTW'(1);
            end
          end
          LK_EXACT: begin
            if (hit) scan_next = t;
            else dead_next = 1'b1;
            state_next = ST_IDLE;
          end
          LK_EDGE: begin
            if (hit) begin
              q_we      = 1'b1;
              tail_next = tail + SW'(1);
              snew_next = t;
              if (sd == '0) begin
                f_next     = '0;
                nd_raddr   = '0;
                state_next = ST_BD_ACCF;
              end else begin
                s_next     = sd_fail;
                lk_next    = LK_GO_BUILD;
                state_next = ST_ED_TR;
              end
            end else begin
              cidx_next  = cidx + CCW'(1);
              state_next = ST_BD_C;
            end
          end
          LK_GO_TEXT, LK_GO_BUILD: begin
            if (hit || s == '0) begin
              nd_raddr = '0;
              if (hit) nd_raddr = t;
              if (lk == LK_GO_TEXT) begin
                scan_next  = nd_raddr;
                state_next = ST_TX_ACC;
              end else begin
                f_next     = nd_raddr;
                state_next = ST_BD_ACCF;
              end
            end else begin
              nd_raddr   = s;
              state_next = ST_GO_FAIL;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_GO_FAIL: begin
        s_next     = nd_q.fail;
        state_next = ST_ED_TR;
      end
      ST_EP_RD: begin
        nd_raddr   = cursor;
        state_next = ST_EP_WR;
      end
      ST_EP_WR: begin
        nd_we        = 1'b1;
        nd_waddr     = cursor;
        nd_wdata     = nd_q;
        nd_wdata.acc = 1'b1;
        cursor_next  = '0;
        poison_next  = 1'b0;
        state_next   = ST_RESP;
      end
      ST_ET_RD: begin
        nd_raddr   = scan;
        state_next = ST_ET_ACC;
      end
      ST_ET_ACC: begin
        if (cfg.exact_mode ? (!dead && nd_q.acc) : match) status_next = STAT_MATCH;
        else status_next = STAT_NOMATCH;
        scan_next  = '0;
        match_next = 1'b0;
        dead_next  = 1'b0;
        state_next = ST_RESP;
      end
      ST_BD_SD: begin
        nd_raddr   = sd;
        state_next = ST_BD_SDF;
      end
      ST_BD_SDF: begin
        sd_fail_next = nd_q.fail;
        cidx_next    = CCW'(1);
        state_next   = ST_BD_C;
      end
      ST_BD_C: begin
        if (cidx >= ccount) begin
          state_next = ST_BD_POP;
        end else begin
          s_next     = sd;
          k_next     = cidx[CW-1:0];
          lk_next    = LK_EDGE;
          state_next = ST_ED_TR;
        end
      end
      ST_BD_ACCF: begin
        accf_next  = nd_q.acc;
        nd_raddr   = snew;
        state_next = ST_BD_WR;
      end
      ST_BD_WR: begin
        nd_we         = 1'b1;
        nd_waddr      = snew;
        nd_wdata      = nd_q;
        nd_wdata.fail = f;
        nd_wdata.acc  = nd_q.acc | accf;
        cidx_next     = cidx + CCW'(1);
        state_next    = ST_BD_C;
      end
      ST_BD_POP: begin
        if (head == tail) begin
          status_next = STAT_OK;
          state_next  = ST_RESP;
        end else begin
          head_next  = head + SW'(1);
          state_next = ST_BD_QRD;
        end
      end
      ST_BD_QRD: begin
        sd_next    = q_rdata;
        state_next = ST_BD_SD;
      end
      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign res_status = status;
  assign res_used   = scount;

  assert property (@(posedge clk) disable iff (rst) CNTW'(cursor) < scount)
    else $error("trie cursor outside allocated states");
  assert property (@(posedge clk) disable iff (rst) CNTW'(scan) < scount)
    else $error("scan state outside allocated states");
  assert property (@(posedge clk) disable iff (rst)
    scount <= CNTW'(MAX_STATES) && ccount <= CCW'(MAX_CLASSES) && ccount != '0)
    else $error("state or class count out of range");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_RESP && !res_ready |=> state == ST_RESP && $stable(status) && $stable(scount))
    else $error("pending result changed before it was taken");

endmodule
